// ===== design/e2e7m_pkg.sv =====
package e2e7m_pkg;

    // message geometry
    localparam int unsigned MAX_MSG_BYTES_DEF = 4096;
    localparam int unsigned HDR_BYTES         = 24;
    localparam int unsigned CRC_FIELD_BYTES   = 8;
    localparam int unsigned LEN_FIELD_END     = 12;
    localparam int unsigned CNT_FIELD_END     = 16;
    localparam int unsigned ID_FIELD_END      = 20;

    localparam logic [63:0] CRC_POLY_REFL = 64'hC96C_5795_D787_0F42;
    localparam logic [63:0] CRC_INIT      = 64'hFFFF_FFFF_FFFF_FFFF;

    // expected type / result codes above this are invalid
    localparam logic [1:0] MSG_CODE_MAX = 2'd1;

    // output queue
    localparam int unsigned OUTQ_DEPTH = 3;
    localparam int unsigned OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [2:0] {
        CHK_OK           = 3'd0,
        CHK_OK_SOME_LOST = 3'd1,
        CHK_ERROR        = 3'd2,
        CHK_REPEATED     = 3'd3,
        CHK_NO_NEW_DATA  = 3'd4,
        CHK_WRONG_SEQ    = 3'd5
    } t_chk_status;

    typedef enum logic [2:0] {
        SM_OK          = 3'd0,
        SM_ERROR       = 3'd1,
        SM_REPEATED    = 3'd2,
        SM_NO_NEW_DATA = 3'd3,
        SM_WRONG_SEQ   = 3'd4
    } t_sm_status;

    typedef enum logic [2:0] {
        CFG_HDR_OFFSET  = 3'd0,
        CFG_EXP_DATA_ID = 3'd1,
        CFG_MAX_DELTA   = 3'd2,
        CFG_MIN_LEN     = 3'd3,
        CFG_MAX_LEN     = 3'd4,
        CFG_SINK_MODE   = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        RC_OK          = 1'b0,
        RC_WRONG_INPUT = 1'b1
    } t_ret_code;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        no_data;
        logic [27:0] exp_source_id;
        logic [1:0]  exp_msg_type;
        logic [1:0]  exp_msg_result;
    } t_in_word;

    typedef struct packed {
        logic        return_code;
        logic [2:0]  check_status;
        logic [2:0]  sm_status;
        logic [27:0] received_source_id;
        logic [31:0] received_counter;
    } t_out_word;

    typedef struct packed {
        logic [2:0]  reg_idx;
        logic [31:0] wdata;
    } t_cfg_word;

    function automatic t_sm_status sm_map(input logic [2:0] s);
        t_sm_status r;
        unique case (s)
            CHK_OK, CHK_OK_SOME_LOST: r = SM_OK;
            CHK_REPEATED:             r = SM_REPEATED;
            CHK_NO_NEW_DATA:          r = SM_NO_NEW_DATA;
            CHK_WRONG_SEQ:            r = SM_WRONG_SEQ;
            default:                  r = SM_ERROR;
        endcase
        return r;
    endfunction

    // reflected crc-64, one byte
    function automatic logic [63:0] crc64_byte(input logic [63:0] crc, input logic [7:0] b);
        logic [63:0] c;
        c = crc ^ {56'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== design/e2e7m_chan_if.sv =====
interface e2e7m_chan_if #(
    parameter type T_WORD = logic
) ();
    logic  valid;
    logic  ready;
    T_WORD data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/e2e7m_outq.sv =====
module e2e7m_outq import e2e7m_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_out_word            i_word,
    output logic [OUTQ_CW-1:0]   o_count,
    e2e7m_chan_if.source         o_out
);

    t_out_word          r_q [OUTQ_DEPTH];
    logic [OUTQ_CW-1:0] r_count;
    logic [OUTQ_CW-1:0] n_count;
    logic [OUTQ_CW-1:0] wr_idx;
    logic               pop;

    assign o_out.valid = (r_count != '0);
    assign o_out.data  = r_q[0];
    assign o_count     = r_count;
    assign pop         = o_out.valid && o_out.ready;
    assign n_count     = r_count + OUTQ_CW'(i_push) - OUTQ_CW'(pop);
    assign wr_idx      = pop ? (r_count - OUTQ_CW'(1)) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // head always at slot 0, shift on pop
    always_ff @(posedge i_clk) begin
        if (pop) begin
            for (int i = 0; i < OUTQ_DEPTH - 1; i++) begin
                r_q[i] <= r_q[i + 1];
            end
        end
        if (i_push) begin
            for (int i = 0; i < OUTQ_DEPTH; i++) begin
                if (wr_idx == OUTQ_CW'(i)) begin
                    r_q[i] <= i_word;
                end
            end
        end
    end

endmodule

// ===== design/e2e_profile7m_check.sv =====
// profile 7m end-to-end receive check
//
// channels: i_cfg takes register writes (index + data), always ready; write
// only while the block is idle. i_in takes one word per message byte, from
// byte zero to the word flagged last_byte, or a no_data word that stands for
// a cycle without a new message. o_out gives one result word per last byte
// and per no_data word; other words give none.
// path: an accepted word is held in the input register and checked there
// combinationally; its result is written into the result queue, whose head
// drives o_out.
// throughput: one word per cycle while o_out keeps taking results; ready comes
// from credit over the input register plus the three-entry result queue, so
// i_in keeps taking bytes while results wait as long as queue room remains.
// receiver stall: results queue up; once queue plus the word in flight fill it,
// i_in.ready drops until o_out moves a word or a word with no result leaves.
// reset: config goes to its defaults, last counter to all ones, status to
// error, and any partly received message is dropped.
module e2e_profile7m_check import e2e7m_pkg::*; #(
    parameter int unsigned MAX_MSG_BYTES = MAX_MSG_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    e2e7m_chan_if.sink    i_cfg,
    e2e7m_chan_if.sink    i_in,
    e2e7m_chan_if.source  o_out
);

    localparam int unsigned CW = $clog2(MAX_MSG_BYTES + 2);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_MSG_BYTES);
    localparam logic [CW-1:0] CNT_SAT = CW'(MAX_MSG_BYTES + 1);
    localparam logic [31:0]   LEN_MAX = 32'(MAX_MSG_BYTES);

    // configuration registers
    logic [11:0] r_hdr_off;
    logic [31:0] r_exp_id;
    logic [31:0] r_max_delta;
    logic [12:0] r_min_len;
    logic [12:0] r_max_len;
    logic        r_sink_mode;

    // input register
    logic     r_in_v;
    t_in_word r_in;

    // receive state
    logic [31:0]  r_last_counter, n_last_counter;
    t_chk_status  r_status, n_status;
    logic [CW-1:0] r_byte_count, n_byte_count;
    logic [63:0]  r_crc_acc, n_crc_acc;
    logic [63:0]  r_rx_crc, n_rx_crc;
    logic [31:0]  r_rx_length, n_rx_length;
    logic [31:0]  r_rx_data_id, n_rx_data_id;
    logic [31:0]  r_rx_src_word, n_rx_src_word;
    logic [31:0]  r_rx_count, n_rx_count;

    // result queue handshake
    logic               push;
    t_out_word          res_word;
    logic [OUTQ_CW-1:0] q_count;

    // byte-stage intermediates
    logic [31:0] pos32, off32, rel32, len32, delta;
    logic        in_hdr, in_crc_field, overflow, wrong, match;
    logic [1:0]  rtype, rres;
    logic [27:0] rsrc;
    logic        in_fire;

    assign in_fire     = i_in.valid && i_in.ready;
    // credit: a slot for every word that may still land in the queue
    assign i_in.ready  = (3'(q_count) + 3'(r_in_v)) < 3'(OUTQ_DEPTH);
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in.data;
        end
    end

    // register writes, unlisted indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_off   <= '0;
            r_exp_id    <= '0;
            r_max_delta <= 32'd1;
            r_min_len   <= 13'(HDR_BYTES);
            r_max_len   <= 13'd4096;
            r_sink_mode <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.data.reg_idx))
                CFG_HDR_OFFSET:  r_hdr_off   <= i_cfg.data.wdata[11:0];
                CFG_EXP_DATA_ID: r_exp_id    <= i_cfg.data.wdata;
                CFG_MAX_DELTA:   r_max_delta <= i_cfg.data.wdata;
                CFG_MIN_LEN:     r_min_len   <= i_cfg.data.wdata[12:0];
                CFG_MAX_LEN:     r_max_len   <= i_cfg.data.wdata[12:0];
                CFG_SINK_MODE:   r_sink_mode <= i_cfg.data.wdata[0];
                default: ;
            endcase
        end
    end

    // byte capture, crc update, gap words and end-of-message check
    always_comb begin
        n_last_counter = r_last_counter;
        n_status       = r_status;
        n_byte_count   = r_byte_count;
        n_crc_acc      = r_crc_acc;
        n_rx_crc       = r_rx_crc;
        n_rx_length    = r_rx_length;
        n_rx_data_id   = r_rx_data_id;
        n_rx_src_word  = r_rx_src_word;
        n_rx_count     = r_rx_count;
        push           = 1'b0;
        res_word       = '0;

        pos32        = 32'(r_byte_count);
        off32        = 32'(r_hdr_off);
        rel32        = pos32 - off32;
        in_hdr       = (pos32 >= off32) && (pos32 < off32 + 32'(HDR_BYTES));
        in_crc_field = in_hdr && (rel32 < 32'(CRC_FIELD_BYTES));
        overflow     = (r_byte_count >= CNT_MAX);

        // header capture into the byte-shifted fields, crc over bytes outside the crc field, saturating byte count
        if (overflow) begin
            n_byte_count = CNT_SAT;
        end else begin
            if (in_hdr) begin
                if (rel32 < 32'(CRC_FIELD_BYTES)) begin
                    n_rx_crc = {r_rx_crc[55:0], r_in.data_byte};
                end else if (rel32 < 32'(LEN_FIELD_END)) begin
                    n_rx_length = {r_rx_length[23:0], r_in.data_byte};
                end else if (rel32 < 32'(CNT_FIELD_END)) begin
                    n_rx_count = {r_rx_count[23:0], r_in.data_byte};
                end else if (rel32 < 32'(ID_FIELD_END)) begin
                    n_rx_data_id = {r_rx_data_id[23:0], r_in.data_byte};
                end else begin
                    n_rx_src_word = {r_rx_src_word[23:0], r_in.data_byte};
                end
            end
            if (!in_crc_field) begin
                n_crc_acc = crc64_byte(r_crc_acc, r_in.data_byte);
            end
            n_byte_count = r_byte_count + CW'(1);
        end

        len32 = 32'(n_byte_count);
        wrong = (len32 > LEN_MAX) || (len32 < 32'(r_min_len)) ||
                (len32 > 32'(r_max_len)) || (len32 < off32 + 32'(HDR_BYTES)) ||
                (r_in.exp_msg_type > MSG_CODE_MAX) || (r_in.exp_msg_result > MSG_CODE_MAX);

        rtype = n_rx_src_word[31:30];
        rres  = n_rx_src_word[29:28];
        rsrc  = n_rx_src_word[27:0];
        match = (n_rx_crc == ~n_crc_acc) && (n_rx_data_id == r_exp_id) &&
                (r_sink_mode || (rsrc == r_in.exp_source_id)) &&
                (rtype == r_in.exp_msg_type) && (rres == r_in.exp_msg_result) &&
                (n_rx_length == len32);
        delta = n_rx_count - r_last_counter;

        if (r_in_v && r_in.no_data) begin
            // gap word: message state untouched
            n_byte_count  = r_byte_count;
            n_crc_acc     = r_crc_acc;
            n_rx_crc      = r_rx_crc;
            n_rx_length   = r_rx_length;
            n_rx_data_id  = r_rx_data_id;
            n_rx_src_word = r_rx_src_word;
            n_rx_count    = r_rx_count;
            n_status      = CHK_NO_NEW_DATA;
            push          = 1'b1;
            res_word.return_code  = RC_OK;
            res_word.check_status = CHK_NO_NEW_DATA;
            res_word.sm_status    = SM_NO_NEW_DATA;
        end else if (r_in_v && r_in.last_byte) begin
            push = 1'b1;
            if (wrong) begin
                res_word.return_code  = RC_WRONG_INPUT;
                res_word.check_status = r_status;
                res_word.sm_status    = SM_ERROR;
            end else begin
                if (match) begin
                    // modular counter step
                    if (delta <= r_max_delta) begin
                        if (delta == 32'd0) begin
                            n_status = CHK_REPEATED;
                        end else if (delta == 32'd1) begin
                            n_status = CHK_OK;
                        end else begin
                            n_status = CHK_OK_SOME_LOST;
                        end
                    end else begin
                        n_status = CHK_WRONG_SEQ;
                    end
                    n_last_counter = n_rx_count;
                end else begin
                    n_status = CHK_ERROR;
                end
                res_word.return_code        = RC_OK;
                res_word.check_status       = n_status;
                res_word.sm_status          = sm_map(n_status);
                res_word.received_source_id = rsrc;
                res_word.received_counter   = n_rx_count;
            end
            // end of message: back to a fresh capture
            n_byte_count  = '0;
            n_crc_acc     = CRC_INIT;
            n_rx_crc      = '0;
            n_rx_length   = '0;
            n_rx_data_id  = '0;
            n_rx_src_word = '0;
            n_rx_count    = '0;
        end else if (!r_in_v) begin
            n_byte_count  = r_byte_count;
            n_crc_acc     = r_crc_acc;
            n_rx_crc      = r_rx_crc;
            n_rx_length   = r_rx_length;
            n_rx_data_id  = r_rx_data_id;
            n_rx_src_word = r_rx_src_word;
            n_rx_count    = r_rx_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_counter <= 32'hFFFF_FFFF;
            r_status       <= CHK_ERROR;
            r_byte_count   <= '0;
            r_crc_acc      <= CRC_INIT;
            r_rx_crc       <= '0;
            r_rx_length    <= '0;
            r_rx_data_id   <= '0;
            r_rx_src_word  <= '0;
            r_rx_count     <= '0;
        end else begin
            r_last_counter <= n_last_counter;
            r_status       <= n_status;
            r_byte_count   <= n_byte_count;
            r_crc_acc      <= n_crc_acc;
            r_rx_crc       <= n_rx_crc;
            r_rx_length    <= n_rx_length;
            r_rx_data_id   <= n_rx_data_id;
            r_rx_src_word  <= n_rx_src_word;
            r_rx_count     <= n_rx_count;
        end
    end

    e2e7m_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (res_word),
        .o_count (q_count),
        .o_out   (o_out)
    );

endmodule
